// ----- hw/rtl/htfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and helper functions for the humidity/temperature
// response frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] HUM_SPAN    = 15'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUM_CRC  = 2'd2
  } status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: one add and one compare correction
  function automatic logic [15:0] div_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + {15'd0, (r >= 17'd65535)};
  endfunction

endpackage

// ----- hw/rtl/humidity_temp_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes a six-byte sensor measurement response into temperature and
// humidity in hundredths, with CRC-8 checking of both words.
// ----------------------------------------------------------------------------
// Takes one response byte per cycle while in_stall is low, with no gaps
// needed between frames; a frame_start byte restarts the frame and drops any
// partial one. The CRC-8 runs on each word byte as it arrives, and the scaling
// of both words goes through a two-register path (constant multiply, then
// divide-by-65535 correction) once the sixth byte is accepted. Input is held
// off only while both scaling registers are full and the output stalls.
module humidity_temp_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [1:0]         status
);
  import htfd_pkg::*;

  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_check_ok;

  logic        mid_valid;
  status_t     mid_status;
  logic [30:0] prod_temp;
  logic [29:0] prod_hum;

  logic [2:0]  pos;
  logic [7:0]  crc_next;
  logic        in_accept;
  logic        fire_last;
  logic        out_load;
  logic        mid_load;
  status_t     status_next;
  logic [15:0] q_temp;
  logic [15:0] q_hum;
  logic signed [15:0] temp_full;

  assign out_load  = !out_valid || !out_stall;
  assign mid_load  = !mid_valid || out_load;
  assign in_stall  = !mid_load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    pos = (frame_start || byte_position > POS_HUM_CRC) ? POS_TEMP_HI : byte_position;
    if (pos == POS_TEMP_HI || pos == POS_HUM_HI) begin
      crc_next = crc8_byte(CRC_INIT, data_byte);
    end else begin
      crc_next = crc8_byte(running_crc, data_byte);
    end
    fire_last = in_accept && (pos == POS_HUM_CRC);
    if (!temp_check_ok) begin
      status_next = ST_TEMP_CRC;
    end else if (running_crc != data_byte) begin
      status_next = ST_HUM_CRC;
    end else begin
      status_next = ST_OK;
    end
    q_temp    = div_65535(prod_temp);
    q_hum     = div_65535({1'b0, prod_hum});
    temp_full = $signed({1'b0, q_temp[14:0]}) - TEMP_OFFSET;
  end

  // frame state: advance on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_TEMP_HI;
      running_crc   <= CRC_INIT;
      temp_check_ok <= 1'b0;
    end else if (in_accept) begin
      byte_position <= (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
      case (pos)
        POS_TEMP_HI, POS_TEMP_LO, POS_HUM_HI, POS_HUM_LO: running_crc <= crc_next;
        POS_TEMP_CRC: temp_check_ok <= (running_crc == data_byte);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      case (pos)
        POS_TEMP_HI: temp_word[15:8] <= data_byte;
        POS_TEMP_LO: temp_word[7:0]  <= data_byte;
        POS_HUM_HI:  hum_word[15:8]  <= data_byte;
        POS_HUM_LO:  hum_word[7:0]   <= data_byte;
        default: ;
      endcase
    end
  end

  // scaling stage: constant multiply of both words
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_load) begin
      mid_valid <= fire_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      mid_status <= status_next;
      prod_temp  <= 31'(temp_word) * 31'(TEMP_SPAN);
      prod_hum   <= 30'(hum_word) * 30'(HUM_SPAN);
    end
  end

  // result stage: divide by 65535 and offset, zeroing both fields on a CRC error
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && mid_valid) begin
      status <= mid_status;
      if (mid_status == ST_OK) begin
        temperature_centi <= temp_full[14:0];
        humidity_centi    <= q_hum[13:0];
      end else begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
      end
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_HUM_CRC)
    else $error("byte position out of range");

  a_last_byte_loads: assert property (@(posedge clk) disable iff (rst)
    fire_last |=> mid_valid)
    else $error("sixth byte did not load scaling stage");

  a_mid_held: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !out_load |=> mid_valid && $stable(prod_temp) && $stable(prod_hum))
    else $error("pending result lost in scaling stage");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)
    else $error("error result carries nonzero fields");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_centi <= 14'd10000)
    else $error("humidity above full scale");
`endif

endmodule

// ----- test/humidity_temp_frame_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_test
// Drives six-byte measurement responses into the frame decoder one byte per
// request and checks every decoded reading against a local decoder model.
// The directed responses cover the extreme words, good and bad CRCs, an
// aborted frame and frames back to back. Random responses follow under three
// handshake idle patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_test;
  import htfd_pkg::*;

  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 540;

  typedef struct packed {
    logic [7:0] b;
    logic       fs;
  } byte_req_t;

  typedef struct packed {
    logic [14:0] temp;
    logic [13:0] hum;
    status_t     st;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [1:0]         status;

  byte_req_t pending_bytes[$];
  reading_t  expected_readings[$];
  byte_req_t next_req;
  reading_t  oldest_reading;

  // decoder model state
  logic [2:0]  frame_pos = POS_TEMP_HI;
  logic [7:0]  crc_acc = CRC_INIT;
  logic [15:0] temp_bits = 16'h0000;
  logic [15:0] hum_raw = 16'h0000;
  logic        temp_ok = 1'b0;

  int phase = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  int errors = 0;

  humidity_temp_frame_decoder dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .status            (status)
  );

  always #10 clk = ~clk;

  // bit-serial CRC-8, message bits MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[7] ^ b[k]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  task automatic decode_response_byte(input logic [7:0] b, input logic fs);
    reading_t   r;
    logic [2:0] pos;
    int         t;
    int         h;
    pos = (fs || frame_pos > POS_HUM_CRC) ? POS_TEMP_HI : frame_pos;
    case (pos)
      POS_TEMP_HI: begin
        temp_bits = {b, 8'h00};
        crc_acc = crc8_next(CRC_INIT, b);
      end
      POS_TEMP_LO: begin
        temp_bits[7:0] = b;
        crc_acc = crc8_next(crc_acc, b);
      end
      POS_TEMP_CRC: begin
        temp_ok = (crc_acc == b);
      end
      POS_HUM_HI: begin
        hum_raw = {b, 8'h00};
        crc_acc = crc8_next(CRC_INIT, b);
      end
      POS_HUM_LO: begin
        hum_raw[7:0] = b;
        crc_acc = crc8_next(crc_acc, b);
      end
      default: begin
        if (!temp_ok) begin
          r.st = ST_TEMP_CRC;
        end else if (crc_acc != b) begin
          r.st = ST_HUM_CRC;
        end else begin
          r.st = ST_OK;
        end
        t = 0;
        h = 0;
        if (r.st == ST_OK) begin
          t = -4500 + (17500 * int'(temp_bits)) / 65535;
          h = (10000 * int'(hum_raw)) / 65535;
        end
        r.temp = t[14:0];
        r.hum = h[13:0];
        expected_readings.push_back(r);
      end
    endcase
    frame_pos = (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic fs);
    byte_req_t req;
    req.b = b;
    req.fs = fs;
    pending_bytes.push_back(req);
  endfunction

  // queue the first n bytes of a response, flipping CRC bits where asked
  function automatic void queue_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                                      input logic fs, input logic [7:0] t_flip,
                                      input logic [7:0] h_flip, input int n);
    logic [7:0] frame [6];
    frame[0] = t_word[15:8];
    frame[1] = t_word[7:0];
    frame[2] = word_crc(t_word) ^ t_flip;
    frame[3] = h_word[15:8];
    frame[4] = h_word[7:0];
    frame[5] = word_crc(h_word) ^ h_flip;
    for (int i = 0; i < n; i++) begin
      queue_byte(frame[i], (i == 0) ? fs : 1'b0);
    end
  endfunction

  function automatic logic [15:0] pick_word();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic logic [7:0] pick_flip();
    if ($urandom_range(9, 0) != 0) return 8'h00;
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic load_directed();
    queue_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00, 6);
    queue_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 6);
    queue_frame(16'h6666, 16'h9999, 1'b1, 8'h00, 8'h00, 2);
    queue_frame(16'h1234, 16'hABCD, 1'b1, 8'h00, 8'h80, 6);
    queue_frame(16'h8000, 16'h7FFF, 1'b0, 8'hFF, 8'h5A, 6);
  endtask

  // mostly clean responses, some aborted frames and some raw noise
  task automatic load_random(input int count);
    int          made;
    int          pick;
    int          n;
    bit          aligned;
    logic [15:0] t_word;
    logic [15:0] h_word;
    made = 0;
    aligned = 1'b0;
    while (made < count) begin
      pick = $urandom_range(99, 0);
      t_word = pick_word();
      h_word = pick_word();
      if (pick < 80) begin
        queue_frame(t_word, h_word, !aligned || $urandom_range(1, 0) == 1,
                    pick_flip(), pick_flip(), 6);
        made += 6;
        aligned = 1'b1;
      end else if (pick < 90) begin
        n = $urandom_range(5, 1);
        queue_frame(t_word, h_word, 1'b1, 8'h00, 8'h00, n);
        made += n;
        aligned = 1'b0;
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) queue_byte(8'($urandom_range(255, 0)), $urandom_range(4, 0) == 0);
        made += n;
        aligned = 1'b0;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_response_byte(data_byte, frame_start);
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_req = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_req.b;
          frame_start <= next_req.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading: expected none, actual temp %0d hum %0d status %0d",
                   $time, temperature_centi, humidity_centi, status);
          errors++;
        end else begin
          oldest_reading = expected_readings.pop_front();
          if (temperature_centi !== oldest_reading.temp) begin
            $display("%0t: temperature_centi expected %0d actual %0d", $time,
                     $signed(oldest_reading.temp), temperature_centi);
            errors++;
          end
          if (humidity_centi !== oldest_reading.hum) begin
            $display("%0t: humidity_centi expected %0d actual %0d", $time,
                     oldest_reading.hum, humidity_centi);
            errors++;
          end
          if (status !== oldest_reading.st) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     oldest_reading.st, status);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (phase == 2 && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int settle;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      phase = ph;
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 22 : 0;
      if (ph == 0) load_directed();
      load_random(RANDOM_BYTES);
      while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    end
    settle = 0;
    while (expected_readings.size() != 0 && settle < 500) begin
      @(negedge clk);
      settle++;
    end
    repeat (8) @(negedge clk);
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d readings expected but never delivered", $time,
               expected_readings.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/htfd_pkg.sv
hw/rtl/humidity_temp_frame_decoder.sv
test/humidity_temp_frame_decoder_test.sv
